>>> src/bmp_rle_pixel_encoder_core_defines.svh
// Assertion macros used by the encoder core.
// They assume a clock named clk and an active-low reset named arst_n.
`ifndef BMP_RLE_PIXEL_ENCODER_CORE_DEFINES_SVH
`define BMP_RLE_PIXEL_ENCODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRLE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brle: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brle: next-cycle check failed");

`endif

>>> src/brle_pkg.sv
package brle_pkg;

	localparam int unsigned BURST_MAX = 6;
	localparam int unsigned CNT_W = $clog2(BURST_MAX + 1);

	localparam logic [7:0] RUN_MAX = 8'd255;
	localparam logic [7:0] MARK_ESC = 8'h00;
	localparam logic [7:0] MARK_EOL = 8'h00;
	localparam logic [7:0] MARK_EOD = 8'h01;

	localparam logic REG_NIBBLE_MODE = 1'b0;
	localparam logic REG_ROW_WIDTH = 1'b1;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [7:0] run_first;
		logic [3:0] run_second;
		logic [7:0] run_length;
		logic [15:0] row_left;
	} run_state_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0] count;
		logic fin;
	} burst_t;

	function automatic byte_t run_value(input logic nibble, input logic [7:0] first,
			input logic [3:0] second);
		run_value = nibble ? {first[3:0], second} : first;
	endfunction

endpackage

>>> src/brle_encode.sv
module brle_encode (
	input logic [7:0] pixel,
	input logic fin,
	input logic nibble_mode,
	input logic [15:0] row_width,
	input brle_pkg::run_state_t cur,
	output brle_pkg::run_state_t nxt,
	output brle_pkg::burst_t burst
);

	logic [7:0] p;
	logic open_run;
	logic joins;
	logic close_old;
	logic row_end;
	logic shut;
	logic [7:0] len_new;
	logic [7:0] first_new;
	logic [3:0] second_new;
	brle_pkg::byte_t val_old;
	brle_pkg::byte_t val_new;
	brle_pkg::byte_t mark;

	always_comb begin
		p = nibble_mode ? {4'b0, pixel[3:0]} : pixel;
		open_run = (cur.run_length != 8'd0);
		if (cur.run_length >= brle_pkg::RUN_MAX) begin
			joins = 1'b0;
		end else if (!nibble_mode) begin
			joins = (p == cur.run_first);
		end else if (cur.run_length == 8'd1) begin
			joins = 1'b1;
		end else if (!cur.run_length[0]) begin
			joins = (p[3:0] == cur.run_first[3:0]);
		end else begin
			joins = (p[3:0] == cur.run_second);
		end
		close_old = open_run && !joins;

		if (open_run && joins) begin
			len_new = cur.run_length + 8'd1;
			first_new = cur.run_first;
			second_new = (nibble_mode && cur.run_length == 8'd1) ? p[3:0] : cur.run_second;
		end else begin
			len_new = 8'd1;
			first_new = p;
			second_new = 4'd0;
		end

		row_end = (cur.row_left <= 16'd1);
		shut = row_end || fin;
		val_old = brle_pkg::run_value(nibble_mode, cur.run_first, cur.run_second);
		val_new = brle_pkg::run_value(nibble_mode, first_new, second_new);
		mark = fin ? brle_pkg::MARK_EOD : brle_pkg::MARK_EOL;

		if (close_old) begin
			burst.bytes[0] = cur.run_length;
			burst.bytes[1] = val_old;
			burst.bytes[2] = len_new;
			burst.bytes[3] = val_new;
			burst.bytes[4] = brle_pkg::MARK_ESC;
			burst.bytes[5] = mark;
		end else begin
			burst.bytes[0] = len_new;
			burst.bytes[1] = val_new;
			burst.bytes[2] = brle_pkg::MARK_ESC;
			burst.bytes[3] = mark;
			burst.bytes[4] = 8'd0;
			burst.bytes[5] = 8'd0;
		end
		burst.count = (close_old ? brle_pkg::CNT_W'(2) : brle_pkg::CNT_W'(0))
			+ (shut ? brle_pkg::CNT_W'(4) : brle_pkg::CNT_W'(0));
		burst.fin = fin;

		nxt.run_first = first_new;
		nxt.run_second = second_new;
		nxt.run_length = shut ? 8'd0 : len_new;
		nxt.row_left = shut ? row_width : cur.row_left - 16'd1;
	end

endmodule

>>> src/brle_burst_buf.sv
module brle_burst_buf (
	input logic clk,
	input logic arst_n,
	input logic load,
	input brle_pkg::burst_t burst,
	output logic can_take,
	output logic [brle_pkg::CNT_W-1:0] level,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,
	output logic m_tlast,
	output logic m_tuser
);

	logic [brle_pkg::BURST_MAX-1:0][7:0] bytes_q;
	logic [brle_pkg::CNT_W-1:0] cnt_q;
	logic fin_q;
	logic pop;

	assign pop = (cnt_q != '0) && m_tready;
	assign can_take = (cnt_q == '0) || ((cnt_q == brle_pkg::CNT_W'(1)) && m_tready);
	assign level = cnt_q;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata = bytes_q[0];
	assign m_tlast = (cnt_q == brle_pkg::CNT_W'(1));
	assign m_tuser = (cnt_q == brle_pkg::CNT_W'(1)) && fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.count;
		end else if (pop) begin
			cnt_q <= cnt_q - brle_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
			fin_q <= burst.fin;
		end else if (pop) begin
			for (int i = 0; i < brle_pkg::BURST_MAX - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule

>>> src/bmp_rle_pixel_encoder_core.sv
// BMP RLE8/RLE4 run encoder for a stream of palette indices.
// Input channel s_*: one pixel per item in raster order; s_tdata carries the
// palette index and s_tlast marks the final pixel of the image.
// Output channel m_*: one encoded byte per item; m_tlast marks the last byte
// that a pixel releases and m_tuser marks the 01 byte of the end-of-data pair.
// Registers on the APB port: nibble_mode at address 0, row_width at address 4.
// Write them only while the encoder is idle.
// A pixel waits in the input register until the output buffer can take it, and
// then loads its burst of zero, two, four or six bytes into the output buffer, so
// the first byte of a burst passes through the input register and the buffer.
// The buffer sends one byte per cycle while m_tready is high; a pixel that only
// extends the open run releases no bytes.
// A new pixel is taken while the previous burst is still draining.
// When m_tready is low, the buffer holds its byte and the input stalls behind it.
// Reset clears the open run, selects RLE8, sets the row width to one and
// empties both registers.
`include "bmp_rle_pixel_encoder_core_defines.svh"

module bmp_rle_pixel_encoder_core (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] pixel_index
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // [7:0] out_byte
	output logic m_tlast,
	output logic m_tuser, // [0] stream_end
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic valid_s1;
	logic [7:0] pixel_s1;
	logic fin_s1;
	logic nibble_mode_q;
	logic [15:0] row_width_q;
	brle_pkg::run_state_t state_q;
	brle_pkg::run_state_t state_nxt;
	brle_pkg::burst_t burst;
	logic can_take;
	logic issue;
	logic cfg_we;
	logic [brle_pkg::CNT_W-1:0] level;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == brle_pkg::REG_ROW_WIDTH) ? {16'b0, row_width_q}
		: {31'b0, nibble_mode_q};

	assign issue = valid_s1 && can_take;
	assign s_tready = !valid_s1 || issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (issue) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pixel_s1 <= s_tdata;
			fin_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_mode_q <= 1'b0;
			row_width_q <= 16'd1;
			state_q.run_first <= 8'd0;
			state_q.run_second <= 4'd0;
			state_q.run_length <= 8'd0;
			state_q.row_left <= 16'd1;
		end else begin
			if (issue) begin
				state_q <= state_nxt;
			end
			if (cfg_we) begin
				case (paddr[2])
					brle_pkg::REG_NIBBLE_MODE: begin
						nibble_mode_q <= pwdata[0];
					end
					brle_pkg::REG_ROW_WIDTH: begin
						row_width_q <= pwdata[15:0];
						state_q.row_left <= pwdata[15:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	brle_encode u_encode (
		.pixel(pixel_s1),
		.fin(fin_s1),
		.nibble_mode(nibble_mode_q),
		.row_width(row_width_q),
		.cur(state_q),
		.nxt(state_nxt),
		.burst(burst)
	);

	brle_burst_buf u_burst_buf (
		.clk(clk),
		.arst_n(arst_n),
		.load(issue),
		.burst(burst),
		.can_take(can_take),
		.level(level),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	`BRLE_ASSERT_NOW(a_end_on_last, m_tvalid && m_tuser, m_tlast)
	`BRLE_ASSERT_NOW(a_no_overwrite, level > brle_pkg::CNT_W'(1), !issue)
	`BRLE_ASSERT_NEXT(a_final_clears, issue && fin_s1 && !cfg_we,
		state_q.run_length == 8'd0 && state_q.row_left == row_width_q)

endmodule

>>> sim/bmp_rle_pixel_encoder_core_test.sv
`timescale 1ns / 100ps

module bmp_rle_pixel_encoder_core_test;

	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [7:0] value;
		logic burst_end;
		logic stream_end;
	} enc_byte_t;

	class rle_scoreboard;
		enc_byte_t exp_bytes[$];
		int errors;
		logic nibble_mode;
		logic [15:0] row_width;
		logic [7:0] run_first;
		logic [3:0] run_second;
		logic [7:0] run_length;
		logic [15:0] row_left;

		function new();
			errors = 0;
			nibble_mode = 1'b0;
			row_width = 16'd1;
			run_first = 8'h00;
			run_second = 4'h0;
			run_length = 8'h00;
			row_left = 16'd1;
		endfunction

		function void set_mode(logic mode);
			nibble_mode = mode;
		endfunction

		function void set_width(logic [15:0] width);
			row_width = width;
			row_left = width;
		endfunction

		function int pending();
			return exp_bytes.size();
		endfunction

		function void push(logic [7:0] value, logic stream_end);
			exp_bytes.push_back('{value: value, burst_end: 1'b0, stream_end: stream_end});
		endfunction

		function void start_run(logic [7:0] pix);
			run_first = pix;
			run_second = 4'h0;
			run_length = 8'd1;
		endfunction

		function void close_run();
			if (run_length == 8'd0)
				return;
			push(run_length, 1'b0);
			push(nibble_mode ? {run_first[3:0], run_second} : run_first, 1'b0);
			run_length = 8'd0;
		endfunction

		// Works out the bytes that one accepted pixel releases.
		function void note_pixel(logic [7:0] pix, logic fin);
			logic [7:0] p;
			logic joins;
			logic row_end;
			int n0;
			n0 = exp_bytes.size();
			p = nibble_mode ? {4'h0, pix[3:0]} : pix;
			if (run_length != 8'd0) begin
				if (run_length >= brle_pkg::RUN_MAX)
					joins = 1'b0;
				else if (!nibble_mode)
					joins = (p == run_first);
				else if (run_length == 8'd1)
					joins = 1'b1;
				else if (!run_length[0])
					joins = (p[3:0] == run_first[3:0]);
				else
					joins = (p[3:0] == run_second);
				if (joins) begin
					if (nibble_mode && run_length == 8'd1)
						run_second = p[3:0];
					run_length = run_length + 8'd1;
				end else begin
					close_run();
					start_run(p);
				end
			end else begin
				start_run(p);
			end
			row_end = (row_left <= 16'd1);
			if (row_end || fin)
				close_run();
			if (fin) begin
				push(brle_pkg::MARK_ESC, 1'b0);
				push(brle_pkg::MARK_EOD, 1'b1);
				row_left = row_width;
			end else if (row_end) begin
				push(brle_pkg::MARK_ESC, 1'b0);
				push(brle_pkg::MARK_EOL, 1'b0);
				row_left = row_width;
			end else begin
				row_left = row_left - 16'd1;
			end
			if (exp_bytes.size() > n0)
				exp_bytes[$].burst_end = 1'b1;
		endfunction

		function void check_byte(logic [7:0] value, logic last, logic user);
			enc_byte_t e;
			if (exp_bytes.size() == 0) begin
				$display("%0t: unexpected item: expected none, actual byte %h last %b user %b",
					$time, value, last, user);
				errors++;
				return;
			end
			e = exp_bytes.pop_front();
			if (e.value !== value) begin
				$display("%0t: out_byte mismatch: expected %h, actual %h", $time, e.value, value);
				errors++;
			end
			if (e.burst_end !== last) begin
				$display("%0t: burst_end mismatch: expected %b, actual %b",
					$time, e.burst_end, last);
				errors++;
			end
			if (e.stream_end !== user) begin
				$display("%0t: stream_end mismatch: expected %b, actual %b",
					$time, e.stream_end, user);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rle_scoreboard sb;
	bit no_idle;
	bit hold_req;
	int unsigned cycles;

	bmp_rle_pixel_encoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bmp_rle_pixel_encoder_core_test failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(input logic [7:0] pix, input logic fin);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(pix, fin);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		logic [31:0] rd;
		logic [31:0] want;
		want = (idx == brle_pkg::REG_NIBBLE_MODE) ? {31'b0, val[0]} : {16'b0, val};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= want;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == brle_pkg::REG_NIBBLE_MODE)
			sb.set_mode(val[0]);
		else
			sb.set_width(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== want) begin
			$display("%0t: register %0d readback mismatch: expected %h, actual %h",
				$time, idx, want, rd);
			sb.errors++;
		end
	endtask

	// The receiver stalls at random and once holds off for a long stretch.
	initial begin
		int hold;
		int r;
		bit held;
		hold = 0;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_byte(m_tdata, m_tlast, m_tuser);
			if (hold_req && !held) begin
				held = 1'b1;
				hold = 300;
			end else if (hold == 0 && !no_idle) begin
				r = $urandom_range(0, 99);
				if (r >= 95)
					hold = $urandom_range(8, 30);
				else if (r >= 75)
					hold = $urandom_range(1, 3);
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int r;
		logic [7:0] pix;
		logic [7:0] prev1;
		logic [7:0] prev2;
		logic fin;
		logic mode;
		logic [15:0] width;
		sb = new();
		no_idle = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'b000;
		pwdata = 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Byte runs with row ends, then a final pixel at the start of a row.
		write_reg(brle_pkg::REG_NIBBLE_MODE, 16'd0);
		write_reg(brle_pkg::REG_ROW_WIDTH, 16'd4);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'h12, 1'b1);

		// Nibble runs, with a one-pixel run closed by the final pixel.
		wait_drained();
		write_reg(brle_pkg::REG_NIBBLE_MODE, 16'd1);
		write_reg(brle_pkg::REG_ROW_WIDTH, 16'd6);
		send_pixel(8'h3A, 1'b0);
		send_pixel(8'hF5, 1'b0);
		send_pixel(8'h0A, 1'b0);
		send_pixel(8'h05, 1'b0);
		send_pixel(8'h7C, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'h09, 1'b1);

		// Zero row width acts as one, then a row width of one.
		wait_drained();
		write_reg(brle_pkg::REG_NIBBLE_MODE, 16'd0);
		write_reg(brle_pkg::REG_ROW_WIDTH, 16'd0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h80, 1'b1);
		wait_drained();
		write_reg(brle_pkg::REG_ROW_WIDTH, 16'd1);
		send_pixel(8'h7F, 1'b0);
		send_pixel(8'h7F, 1'b1);

		// The mode changes while a run is open.
		wait_drained();
		write_reg(brle_pkg::REG_ROW_WIDTH, 16'hFFFF);
		send_pixel(8'h11, 1'b0);
		send_pixel(8'h11, 1'b0);
		wait_drained();
		write_reg(brle_pkg::REG_NIBBLE_MODE, 16'd1);
		send_pixel(8'hE1, 1'b0);
		send_pixel(8'h01, 1'b1);

		prev1 = 8'h00;
		prev2 = 8'h00;
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			mode = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 9);
			if (r == 0)
				width = 16'd1;
			else if (r == 9)
				width = 16'($urandom_range(13, 40));
			else
				width = 16'($urandom_range(2, 12));
			write_reg(brle_pkg::REG_NIBBLE_MODE, {15'b0, mode});
			write_reg(brle_pkg::REG_ROW_WIDTH, width);
			no_idle = (ph == 3);
			if (ph == 2)
				hold_req = 1'b1;
			for (int i = 0; i < 23; i++) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					if (mode) begin
						pix = 8'($urandom);
						pix[3:0] = prev2[3:0];
					end else begin
						pix = prev1;
					end
				end else if (r < 72) begin
					pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end else begin
					pix = 8'($urandom);
				end
				fin = ($urandom_range(0, 29) == 0);
				send_pixel(pix, fin);
				prev2 = prev1;
				prev1 = pix;
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("bmp_rle_pixel_encoder_core_test passed");
		else
			$display("bmp_rle_pixel_encoder_core_test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/brle_pkg.sv
src/brle_encode.sv
src/brle_burst_buf.sv
src/bmp_rle_pixel_encoder_core.sv
sim/bmp_rle_pixel_encoder_core_test.sv
